>>> rtl/core/mqdf_pkg.sv
// ----------------------------------------------------------------------------
// mqdf_pkg: shared types and constants of the MQTT receive deframer
// Phase and event codes, protocol constants and the result record passed
// from the parser to the output stage.
// ----------------------------------------------------------------------------
package mqdf_pkg;

	// parser phase; the unused code 3 behaves as header
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_LENGTH = 2'd1,
		PH_BODY   = 2'd2
	} phase_t;

	// per-byte event code
	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_ACCEPTED  = 3'd1,
		EV_REFUSED   = 3'd2,
		EV_PINGRESP  = 3'd3,
		EV_OTHER     = 3'd4,
		EV_MALFORMED = 3'd5
	} event_t;

	localparam int unsigned LEN_W = 28;

	localparam logic [3:0] TYPE_CONNACK  = 4'd2;
	localparam logic [3:0] TYPE_PINGRESP = 4'd13;
	localparam logic [2:0] CODE_POS      = 3'd3;
	localparam logic [2:0] POS_MAX       = 3'd7;
	localparam logic [2:0] CONNACK_MIN   = 3'd4;
	localparam logic [7:0] CODE_ACCEPTED = 8'h00;
	localparam logic [1:0] LAST_DIGIT    = 2'd3;

	// one result item
	typedef struct packed {
		event_t     ev;
		logic [3:0] msg_type;
		logic       last;
		logic [7:0] code;
	} result_t;

	// classify a completed message
	function automatic event_t classify(input logic [3:0] mtype, input logic [2:0] pos,
			input logic [7:0] code);
		event_t ev;
		if (mtype == TYPE_CONNACK) begin
			if (pos < CONNACK_MIN)
				ev = EV_REFUSED;
			else if (code == CODE_ACCEPTED)
				ev = EV_ACCEPTED;
			else
				ev = EV_REFUSED;
		end else if (mtype == TYPE_PINGRESP) begin
			ev = EV_PINGRESP;
		end else begin
			ev = EV_OTHER;
		end
		return ev;
	endfunction

endpackage

>>> rtl/core/mqdf_parser.sv
// ----------------------------------------------------------------------------
// mqdf_parser: fixed header parser and body counter
// Holds the frame state, updates it on every accepted byte and produces the
// result for that byte combinationally.
// ----------------------------------------------------------------------------
module mqdf_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	output mqdf_pkg::result_t   res
);
	import mqdf_pkg::*;

	phase_t             phase_q,   phase_d;
	logic [3:0]         type_q,    type_d;
	logic [LEN_W-1:0]   len_q,     len_d;
	logic [1:0]         digits_q,  digits_d;
	logic [LEN_W-1:0]   left_q,    left_d;
	logic [2:0]         pos_q,     pos_d;
	logic [7:0]         code_q,    code_d;

	logic [2:0]         pos_cnt;
	logic [7:0]         code_cnt;
	logic [LEN_W-1:0]   digit_val;
	logic [LEN_W-1:0]   len_new;
	logic [LEN_W-1:0]   left_dec;

	// frame byte counting, capture of the code byte
	always_comb begin
		pos_cnt  = (pos_q != POS_MAX) ? pos_q + 3'd1 : pos_q;
		code_cnt = (pos_q == CODE_POS) ? rx_byte : code_q;
	end

	// place the 7-bit length digit at its weight
	always_comb begin
		unique case (digits_q)
			2'd0: digit_val = {21'd0, rx_byte[6:0]};
			2'd1: digit_val = {14'd0, rx_byte[6:0], 7'd0};
			2'd2: digit_val = {7'd0, rx_byte[6:0], 14'd0};
			2'd3: digit_val = {rx_byte[6:0], 21'd0};
			default: digit_val = '0;
		endcase
		len_new  = len_q | digit_val;
		left_dec = (left_q != '0) ? left_q - LEN_W'(1) : left_q;
	end

	// next state and result
	always_comb begin
		phase_d  = phase_q;
		type_d   = type_q;
		len_d    = len_q;
		digits_d = digits_q;
		left_d   = left_q;
		pos_d    = pos_q;
		code_d   = code_q;
		res.ev   = EV_NONE;
		res.last = 1'b0;
		unique case (phase_q)
			PH_LENGTH: begin
				pos_d  = pos_cnt;
				code_d = code_cnt;
				len_d  = len_new;
				if (rx_byte[7]) begin
					if (digits_q == LAST_DIGIT) begin
						res.ev   = EV_MALFORMED;
						res.last = 1'b1;
						phase_d  = PH_HEADER;
					end else begin
						digits_d = digits_q + 2'd1;
					end
				end else begin
					left_d = len_new;
					if (len_new == '0) begin
						res.ev   = classify(type_q, pos_cnt, code_cnt);
						res.last = 1'b1;
						phase_d  = PH_HEADER;
					end else begin
						phase_d = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				pos_d  = pos_cnt;
				code_d = code_cnt;
				left_d = left_dec;
				if (left_dec == '0) begin
					res.ev   = classify(type_q, pos_cnt, code_cnt);
					res.last = 1'b1;
					phase_d  = PH_HEADER;
				end
			end
			default: begin
				// header byte: new frame, position 0 counted
				type_d   = rx_byte[7:4];
				len_d    = '0;
				digits_d = '0;
				left_d   = '0;
				pos_d    = 3'd1;
				code_d   = '0;
				phase_d  = PH_LENGTH;
			end
		endcase
		res.msg_type = type_d;
		res.code     = code_d;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			type_q   <= '0;
			len_q    <= '0;
			digits_q <= '0;
			left_q   <= '0;
			pos_q    <= '0;
			code_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			type_q   <= type_d;
			len_q    <= len_d;
			digits_q <= digits_d;
			left_q   <= left_d;
			pos_q    <= pos_d;
			code_q   <= code_d;
		end
	end

endmodule

>>> rtl/core/mqtt_receive_deframer_core.sv
// ----------------------------------------------------------------------------
// mqtt_receive_deframer_core: MQTT fixed header deframer
// Splits a received MQTT byte stream into messages and reports each
// message's end with its classification.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the received bytes, one byte per transfer.
//   m_axis returns exactly one result transfer per input byte, in order:
//   event code, message type and captured CONNACK return code in tdata,
//   and tlast set on the byte that completes or aborts a message.
//   A malformed length (fourth length byte with its continuation bit set) gives the malformed event and
//   the following byte is taken as a new header byte.
// Timing:
//   the result is registered and valid in the cycle after its input transfer;
//   one byte is taken every cycle while the output register is empty or m_axis_tready is high,
//   set by the single output register, which reloads in the same cycle its result is taken.
// Reset:
//   arst_n clears the frame state (next byte is a header) and empties the
//   output register.
// Stall:
//   while a result waits with m_axis_tready low, s_axis_tready is low and
//   the frame state holds.
// ----------------------------------------------------------------------------
module mqtt_receive_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	// slave side: [7:0] rx_byte
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	// master side: [2:0] event_res, [6:3] msg_type, [14:7] return_code, [15] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,
	output logic        m_axis_tlast
);
	import mqdf_pkg::*;

	logic    accept;
	result_t res;
	result_t out_q;
	logic    out_valid_q;

	// take a byte whenever the output register is free or being drained
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	mqdf_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (accept),
		.rx_byte (s_axis_tdata),
		.res     (res)
	);

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_q.code, out_q.msg_type, out_q.ev};
	assign m_axis_tlast  = out_q.last;

endmodule

>>> sim/mqtt_receive_deframer_core_test.sv
// ----------------------------------------------------------------------------
// mqtt_receive_deframer_core_test: self-checking bench of the MQTT deframer
// A queue-fed stream driver sends directed frames, then random frames
// (well-formed, non-minimal lengths, truncated, malformed length and noise).
// A software deframer predicts one result per accepted byte, and a monitor
// checks every result transfer field by field in order.
// ----------------------------------------------------------------------------
module mqtt_receive_deframer_core_test;
	import mqdf_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BYTES = 600;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// [7:0] rx_byte
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [2:0] event_res, [6:3] msg_type, [14:7] return_code, [15] zero
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;

	mqtt_receive_deframer_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	// stream bytes waiting to be sent and results waiting to be seen
	logic [7:0] byte_q [$];
	result_t    result_q [$];

	int bytes_sent;
	int results_seen;
	int mismatches;
	int cycles;
	int hold_left;
	bit hold_done;

	// deframer state
	phase_t      ph;
	logic [3:0]  cur_type;
	logic [27:0] len_acc;
	logic [1:0]  len_digits;
	logic [27:0] body_left;
	logic [2:0]  frame_pos;
	logic [7:0]  code_byte;

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// idle percentages per stage of the run
	function automatic int sender_idle();
		if (bytes_sent < 220)
			return 23;
		if (bytes_sent < 440)
			return 77;
		return 0;
	endfunction

	function automatic int receiver_idle();
		if (bytes_sent < 220)
			return 77;
		if (bytes_sent < 440)
			return 23;
		return 0;
	endfunction

	// count one frame byte, latching the connack code position
	function automatic void count_frame_byte(input logic [7:0] b);
		if (frame_pos == CODE_POS)
			code_byte = b;
		if (frame_pos < POS_MAX)
			frame_pos++;
	endfunction

	// classification at message end
	function automatic event_t message_verdict();
		if (cur_type == TYPE_CONNACK) begin
			if (frame_pos < CONNACK_MIN)
				return EV_REFUSED;
			return (code_byte == CODE_ACCEPTED) ? EV_ACCEPTED : EV_REFUSED;
		end
		if (cur_type == TYPE_PINGRESP)
			return EV_PINGRESP;
		return EV_OTHER;
	endfunction

	// advance the deframer by one byte and give its result
	function automatic result_t deframe_byte(input logic [7:0] b);
		result_t r;
		r.ev = EV_NONE;
		r.last = 1'b0;
		case (ph)
			PH_LENGTH: begin
				count_frame_byte(b);
				len_acc = len_acc | (28'(b[6:0]) << (7 * len_digits));
				if (b[7]) begin
					if (len_digits == LAST_DIGIT) begin
						r.ev = EV_MALFORMED;
						r.last = 1'b1;
						ph = PH_HEADER;
					end else begin
						len_digits++;
					end
				end else begin
					body_left = len_acc;
					if (body_left == 28'd0) begin
						r.ev = message_verdict();
						r.last = 1'b1;
						ph = PH_HEADER;
					end else begin
						ph = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				count_frame_byte(b);
				if (body_left > 28'd0)
					body_left--;
				if (body_left == 28'd0) begin
					r.ev = message_verdict();
					r.last = 1'b1;
					ph = PH_HEADER;
				end
			end
			default: begin
				cur_type = b[7:4];
				len_acc = '0;
				len_digits = '0;
				body_left = '0;
				frame_pos = '0;
				code_byte = '0;
				count_frame_byte(b);
				ph = PH_LENGTH;
			end
		endcase
		r.msg_type = cur_type;
		r.code = code_byte;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("mismatch %s at result %0d: got %0h expected %0h",
			field, results_seen, got, want);
		mismatches++;
	endtask

	// one random frame, mostly well formed
	task automatic queue_frame();
		int kind;
		int len;
		int remain;
		int ndig;
		int body_n;
		logic [3:0] mtype;
		logic [7:0] digits [4];
		logic [7:0] b;
		kind = $urandom_range(99);
		// noise byte
		if (kind < 8) begin
			byte_q.push_back(8'($urandom));
			return;
		end
		case ($urandom_range(3))
			0: mtype = TYPE_CONNACK;
			1: mtype = TYPE_PINGRESP;
			default: mtype = 4'($urandom);
		endcase
		byte_q.push_back({mtype, 4'($urandom)});
		// malformed length: four digits all with continuation
		if (kind < 16) begin
			repeat (4) byte_q.push_back(8'($urandom) | 8'h80);
			return;
		end
		if (mtype == TYPE_CONNACK && $urandom_range(1))
			len = 2;
		else if ($urandom_range(99) < 70)
			len = $urandom_range(6);
		else if ($urandom_range(99) < 85)
			len = $urandom_range(200, 7);
		else
			len = $urandom_range(400, 201);
		// base-128 digits, low digit first
		remain = len;
		ndig = 0;
		do begin
			digits[ndig] = 8'(remain % 128);
			remain = remain / 128;
			if (remain > 0)
				digits[ndig][7] = 1'b1;
			ndig++;
		end while (remain > 0);
		// non-minimal encoding with trailing zero digits
		if ($urandom_range(9) == 0) begin
			while (ndig < 4 && $urandom_range(1)) begin
				digits[ndig - 1][7] = 1'b1;
				digits[ndig] = 8'h00;
				ndig++;
			end
		end
		for (int i = 0; i < ndig; i++)
			byte_q.push_back(digits[i]);
		// truncated body now and then
		body_n = (kind < 22) ? $urandom_range(len) : len;
		for (int i = 0; i < body_n; i++) begin
			b = 8'($urandom);
			if (mtype == TYPE_CONNACK && 1 + ndig + i == CODE_POS && $urandom_range(1))
				b = CODE_ACCEPTED;
			byte_q.push_back(b);
		end
	endtask

	// stream driver and prediction of each accepted byte
	always @(posedge clk) begin
		bit taken;
		if (arst_n) begin
			taken = s_axis_tvalid && s_axis_tready;
			if (taken) begin
				result_q.push_back(deframe_byte(s_axis_tdata));
				byte_q.delete(0);
				bytes_sent++;
			end
			if (s_axis_tvalid && !taken) begin
				// hold the offered byte
			end else if (byte_q.size() > 0 && $urandom_range(99) >= sender_idle()) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= byte_q[0];
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// one long hold-off so the block fills and stalls its input
	always @(posedge clk) begin
		if (arst_n) begin
			if (results_seen >= HOLD_AT && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	// result monitor and receiver backpressure
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (result_q.size() == 0) begin
					report_mismatch("unexpected result", m_axis_tdata, 0);
				end else begin
					want = result_q.pop_front();
					if (m_axis_tdata[2:0] != want.ev)
						report_mismatch("event_res", m_axis_tdata[2:0], want.ev);
					if (m_axis_tdata[6:3] != want.msg_type)
						report_mismatch("msg_type", m_axis_tdata[6:3], want.msg_type);
					if (m_axis_tlast != want.last)
						report_mismatch("last_byte", m_axis_tlast, want.last);
					if (m_axis_tdata[14:7] != want.code)
						report_mismatch("return_code", m_axis_tdata[14:7], want.code);
					if (m_axis_tdata[15] != 1'b0)
						report_mismatch("pad bit", m_axis_tdata[15], 0);
				end
				results_seen++;
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= receiver_idle());
			end
		end
	end

	// reset, stimulus and end of run
	initial begin
		logic [7:0] directed [24];
		ph = PH_HEADER;
		cur_type = '0;
		len_acc = '0;
		len_digits = '0;
		body_left = '0;
		frame_pos = '0;
		code_byte = '0;
		directed = '{
			// connack accepted, connack refused
			8'h20, 8'h02, 8'h00, 8'h00,
			8'h20, 8'h02, 8'h00, 8'h05,
			// short connack with zero length, then pingresp
			8'h20, 8'h00,
			8'hD0, 8'h00,
			// fourth length byte with continuation
			8'hF0, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			// code taken from a length digit, non-minimal zero length
			8'h20, 8'h80, 8'h80, 8'h00,
			// type zero, other message
			8'h00, 8'h01, 8'h7F
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed[i])
			byte_q.push_back(directed[i]);
		// sender pauses until every result is in
		while (byte_q.size() > 0 || s_axis_tvalid || result_q.size() > 0)
			@(posedge clk);
		while (byte_q.size() < RANDOM_BYTES)
			queue_frame();
		// drain
		while (byte_q.size() > 0 || s_axis_tvalid || result_q.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (result_q.size() > 0)
			report_mismatch("missing results", 0, result_q.size());
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
